// ----- src/gtfd_pkg.sv -----
// Package for the gamepad text frame decoder: character codes, frame
// positions, the stick word type and the button pair table.
// No dependencies.
`timescale 1ns / 1ps

package gtfd_pkg;

	// Character codes
	localparam logic [7:0] CHAR_TILDE = 8'h7E;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_B     = 8'h42;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// Frame positions; FRAME_LEN also marks idle
	localparam int          POS_W       = 5;
	localparam logic [4:0]  FRAME_LEN   = 5'd18;
	localparam logic [4:0]  POS_OPEN    = 5'd0;
	localparam logic [4:0]  POS_PAIR_LAST = 5'd7;
	localparam logic [4:0]  POS_TRIG    = 5'd8;
	localparam logic [4:0]  POS_STICK_LAST = 5'd16;
	localparam logic [4:0]  POS_LX      = 5'd10;
	localparam logic [4:0]  POS_LY      = 5'd12;
	localparam logic [4:0]  POS_RX      = 5'd14;
	localparam logic [4:0]  POS_RY      = 5'd16;

	// Stick scaling: largest code inside the output range, and 65535/99 rounded up
	localparam int          STICK_MAX_CODE = 99;
	localparam int          STICK_STEP     = 662;

	typedef logic signed [15:0] stick_t;
	typedef logic signed [8:0]  digit_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
	} pair_bits_t;

	// Button bits set by each pair position (1..7)
	function automatic pair_bits_t pair_bits(input logic [2:0] pos);
		pair_bits_t pb;
		begin
			unique case (pos)
				3'd1:    pb = '{first: 16'h1000, second: 16'h2000};
				3'd2:    pb = '{first: 16'h4000, second: 16'h8000};
				3'd3:    pb = '{first: 16'h0010, second: 16'h0020};
				3'd4:    pb = '{first: 16'h0004, second: 16'h0008};
				3'd5:    pb = '{first: 16'h0001, second: 16'h0002};
				3'd6:    pb = '{first: 16'h0100, second: 16'h0200};
				3'd7:    pb = '{first: 16'h0040, second: 16'h0080};
				default: pb = '{first: 16'h0000, second: 16'h0000};
			endcase
			return pb;
		end
	endfunction

endpackage

// ----- src/gtfd_if.sv -----
// Handshake interfaces for the gamepad text frame decoder: character input
// and report output channels. Depends on gtfd_pkg.
`timescale 1ns / 1ps

interface gtfd_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       frame_start;

	modport source (output valid, ch, frame_start, input ready);
	modport sink   (input valid, ch, frame_start, output ready);
endinterface

interface gtfd_report_if;
	logic                valid;
	logic                ready;
	logic [15:0]         buttons;
	logic [7:0]          left_trigger;
	logic [7:0]          right_trigger;
	gtfd_pkg::stick_t    left_x;
	gtfd_pkg::stick_t    left_y;
	gtfd_pkg::stick_t    right_x;
	gtfd_pkg::stick_t    right_y;

	modport source (output valid, buttons, left_trigger, right_trigger,
		left_x, left_y, right_x, right_y, input ready);
	modport sink   (input valid, buttons, left_trigger, right_trigger,
		left_x, left_y, right_x, right_y, output ready);
endinterface

// ----- src/gtfd_stick_scale.sv -----
// Stick scaler: two-digit value to a clamped signed 16-bit stick word.
// Depends on gtfd_pkg.
`timescale 1ns / 1ps

module gtfd_stick_scale (
	input  gtfd_pkg::digit_t high_digit,
	input  logic [7:0]       low_ch,
	output gtfd_pkg::stick_t stick
);
	import gtfd_pkg::*;

	logic signed [12:0] code;
	logic [6:0]         code_lo;
	logic [1:0]         corr;
	logic [16:0]        scaled;

	// Form the decimal code from the held high digit and the low character
	assign code = 13'(high_digit) * 13'sd10
		+ 13'($signed({1'b0, low_ch})) - 13'($signed({1'b0, CHAR_ZERO}));
	assign code_lo = code[6:0];

	// code*65535/99 = 662*code - ceil(code/33) for code in 0..99
	always_comb begin
		if (code_lo == 7'd0) begin
			corr = 2'd0;
		end else if (code_lo <= 7'd33) begin
			corr = 2'd1;
		end else if (code_lo <= 7'd66) begin
			corr = 2'd2;
		end else begin
			corr = 2'd3;
		end
	end

	assign scaled = 17'(code_lo) * 17'(STICK_STEP) - 17'(corr);

	// Clamp outside 0..99, otherwise offset by -32768
	always_comb begin
		if (code < 13'sd0) begin
			stick = 16'sh8000;
		end else if (code > 13'(STICK_MAX_CODE)) begin
			stick = 16'sh7FFF;
		end else begin
			stick = $signed(scaled[15:0] ^ 16'h8000);
		end
	end

endmodule

// ----- src/gamepad_text_frame_decoder.sv -----
// Gamepad text frame decoder: one character per cycle, one report per good frame.
// A closing '~' passes the input stage register, then loads the report into the result register.
// Throughput: one character per cycle; the input stalls only while a report waits.
// Reset: asynchronous, active low; returns to idle until a start-flagged character.
// Depends on gtfd_pkg, gtfd_if and gtfd_stick_scale.
`timescale 1ns / 1ps

module gamepad_text_frame_decoder (
	input  logic         clk,
	input  logic         arst_n,
	gtfd_text_if.sink    text,
	gtfd_report_if.source report
);
	import gtfd_pkg::*;

	// Input stage
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       start_s1;

	// Frame state
	logic [POS_W-1:0] pos_q, pos_d;
	logic             frame_valid_q, frame_valid_d;
	logic [15:0]      buttons_q, buttons_d;
	logic             ltrig_q, ltrig_d;
	logic             rtrig_q, rtrig_d;
	digit_t           hi_q, hi_d;
	stick_t           lx_q, lx_d, ly_q, ly_d, rx_q, rx_d, ry_q, ry_d;

	// Result register
	logic        out_valid_q;
	logic [15:0] out_buttons_q;
	logic        out_ltrig_q, out_rtrig_q;
	stick_t      out_lx_q, out_ly_q, out_rx_q, out_ry_q;

	logic             adv;
	logic             emit;
	logic [POS_W-1:0] eff_pos;
	pair_bits_t       pb;
	stick_t           stick;
	logic             is_a, is_b;

	// Advance the input stage whenever the result register can take a report
	assign adv        = !out_valid_q || report.ready;
	assign text.ready = !vld_s1 || adv;

	gtfd_stick_scale u_scale (
		.high_digit(hi_q),
		.low_ch    (ch_s1),
		.stick     (stick)
	);

	assign eff_pos = start_s1 ? POS_OPEN : pos_q;
	assign pb      = pair_bits(eff_pos[2:0]);
	assign is_a    = (ch_s1 == CHAR_A) || (ch_s1 == CHAR_ONE);
	assign is_b    = (ch_s1 == CHAR_B) || (ch_s1 == CHAR_ONE);

	// Next frame state for the staged character
	always_comb begin
		pos_d         = pos_q;
		frame_valid_d = frame_valid_q;
		buttons_d     = buttons_q;
		ltrig_d       = ltrig_q;
		rtrig_d       = rtrig_q;
		hi_d          = hi_q;
		lx_d          = lx_q;
		ly_d          = ly_q;
		rx_d          = rx_q;
		ry_d          = ry_q;
		emit          = 1'b0;
		if (vld_s1 && adv && (eff_pos < FRAME_LEN)) begin
			pos_d = eff_pos + 5'd1;
			if (eff_pos == POS_OPEN) begin
				frame_valid_d = (ch_s1 == CHAR_TILDE);
				buttons_d     = '0;
				ltrig_d       = 1'b0;
				rtrig_d       = 1'b0;
				hi_d          = '0;
				lx_d          = '0;
				ly_d          = '0;
				rx_d          = '0;
				ry_d          = '0;
			end else begin
				if (ch_s1 == CHAR_NUL) begin
					frame_valid_d = 1'b0;
				end
				if (eff_pos <= POS_PAIR_LAST) begin
					buttons_d = buttons_q | (is_a ? pb.first : 16'h0000)
						| (is_b ? pb.second : 16'h0000);
				end else if (eff_pos == POS_TRIG) begin
					ltrig_d = is_a;
					rtrig_d = is_b;
				end else if (eff_pos <= POS_STICK_LAST) begin
					if (eff_pos[0]) begin
						hi_d = 9'($signed({1'b0, ch_s1})) - 9'($signed({1'b0, CHAR_ZERO}));
					end else begin
						case (eff_pos)
							POS_LX:  lx_d = stick;
							POS_LY:  ly_d = stick;
							POS_RX:  rx_d = stick;
							default: ry_d = stick;
						endcase
					end
				end else begin
					emit          = frame_valid_q && (ch_s1 == CHAR_TILDE);
					frame_valid_d = 1'b0;
				end
			end
		end
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (text.ready) begin
			vld_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1    <= text.ch;
			start_s1 <= text.frame_start;
		end
	end

	// Update control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= FRAME_LEN;
			frame_valid_q <= 1'b0;
		end else begin
			pos_q         <= pos_d;
			frame_valid_q <= frame_valid_d;
		end
	end

	// Hold frame fields
	always_ff @(posedge clk) begin
		buttons_q <= buttons_d;
		ltrig_q   <= ltrig_d;
		rtrig_q   <= rtrig_d;
		hi_q      <= hi_d;
		lx_q      <= lx_d;
		ly_q      <= ly_d;
		rx_q      <= rx_d;
		ry_q      <= ry_d;
	end

	// Result register: load on a report, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_buttons_q <= buttons_q;
			out_ltrig_q   <= ltrig_q;
			out_rtrig_q   <= rtrig_q;
			out_lx_q      <= lx_q;
			out_ly_q      <= ly_q;
			out_rx_q      <= rx_q;
			out_ry_q      <= ry_q;
		end
	end

	assign report.valid         = out_valid_q;
	assign report.buttons       = out_buttons_q;
	assign report.left_trigger  = {8{out_ltrig_q}};
	assign report.right_trigger = {8{out_rtrig_q}};
	assign report.left_x        = out_lx_q;
	assign report.left_y        = out_ly_q;
	assign report.right_x       = out_rx_q;
	assign report.right_y       = out_ry_q;

endmodule
